[src/timestamp_to_epoch_seconds_assert.svh]
// Assertion macros used by the checker of this block.
// Each macro samples on clock; the first two are disabled while reset is high.
`ifndef TIMESTAMP_TO_EPOCH_SECONDS_ASSERT_SVH
`define TIMESTAMP_TO_EPOCH_SECONDS_ASSERT_SVH

`define TS2E_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define TS2E_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`define TS2E_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication across reset");

`endif

[src/ts2e_pkg.sv]
package ts2e_pkg;

   localparam int SECONDS_WIDTH = 38;
   localparam int ADDEND_WIDTH  = 12;
   localparam int FACTOR_WIDTH  = 9;

   localparam logic [4:0] TS_LENGTH  = 5'd14;
   localparam logic [4:0] POS_MONTH  = 5'd4;
   localparam logic [4:0] POS_DAY    = 5'd6;
   localparam logic [4:0] POS_HOUR   = 5'd8;
   localparam logic [4:0] POS_MINUTE = 5'd10;
   localparam logic [4:0] POS_SECOND = 5'd12;
   localparam logic [4:0] POS_MAX    = 5'd31;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [13:0] EPOCH_YEAR = 14'd1970;
   localparam logic [13:0] LEAP_BASE  = 14'd1969;

   localparam logic [6:0] MONTH_FEB  = 7'd2;
   localparam logic [6:0] MONTH_LAST = 7'd12;
   localparam logic [6:0] HOUR_MAX   = 7'd23;
   localparam logic [6:0] MINUTE_MAX = 7'd59;

   localparam logic [5:0] BIT_LAST  = 6'(SECONDS_WIDTH - 1);
   localparam logic [1:0] PASS_LAST = 2'd3;

   // Horner factors: days, then hours, minutes and seconds.
   localparam logic [FACTOR_WIDTH-1:0] PASS_FACTOR [4] = '{9'd365, 9'd24, 9'd60, 9'd60};

   localparam logic [4:0] MONTH_DAYS [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   // Days before the first of each month in a common year.
   localparam logic [8:0] CUM_DAYS [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
   };

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_CHECK,
      ST_SERIAL,
      ST_DONE
   } ts2e_state_type;

   typedef struct packed {
      logic [7:0]               char_code;
      logic                     last_char;
      logic [SECONDS_WIDTH-1:0] fallback_seconds;
   } req_payload_type;

   typedef struct packed {
      logic [SECONDS_WIDTH-1:0] epoch_seconds;
      logic                     time_valid;
   } rsp_payload_type;

endpackage

[src/ts2e_stream_if.sv]
interface ts2e_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/timestamp_to_epoch_seconds.sv]
// Channel    Direction  Payload
// req_chan   in         char_code, last_char, fallback_seconds
// rsp_chan   out        epoch_seconds, time_valid
//
// Characters transfer at one per cycle until the one marked last.
// A valid timestamp then passes through a check state, four bit-serial multiply-accumulate
// passes over the 38-bit value and a load state before the next character is taken.
// An invalid timestamp goes from the check state straight to the load of the fallback.
// Reset is synchronous and clears the character count, the fields and rsp valid.
// A result waits in the output register; while an earlier one is untaken, the new one is held.
module timestamp_to_epoch_seconds
   import ts2e_pkg::*;
(
   input logic           clock,
   input logic           reset,
   ts2e_stream_if.sink   req_chan,
   ts2e_stream_if.source rsp_chan
);

   ts2e_state_type state_ff, state_in;

   logic [4:0]  position_ff, position_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic        bad_ff, bad_in;

   logic [SECONDS_WIDTH-1:0] value_ff, value_in;
   logic [ADDEND_WIDTH-1:0]  addend_ff, addend_in;
   logic [FACTOR_WIDTH-1:0]  carry_ff, carry_in;
   logic [5:0]               bit_ff, bit_in;
   logic [1:0]               pass_ff, pass_in;
   logic                     flag_ff, flag_in;

   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic req_ready;
   logic accept;
   logic bit_end;
   logic serial_end;
   logic out_load;

   logic       is_digit;
   logic [3:0] digit;
   logic       leap;
   logic       month_ok;
   logic [4:0] day_limit;
   logic       stamp_ok;
   logic [ADDEND_WIDTH-1:0]  days_rest;
   logic [FACTOR_WIDTH-1:0]  factor;
   logic [FACTOR_WIDTH:0]    bit_sum;

   function automatic logic [13:0] times_ten_add(logic [13:0] acc, logic [3:0] dig);
      return 14'(acc * 14'd10 + 14'(dig));
   endfunction

   always_comb begin
      req_ready  = (state_ff == ST_ACCUM);
      accept     = req_ready && req_chan.valid;
      bit_end    = (state_ff == ST_SERIAL) && (bit_ff == BIT_LAST);
      serial_end = bit_end && (pass_ff == PASS_LAST);
      out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (accept && req_chan.payload.last_char) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stamp_ok ? ST_SERIAL : ST_DONE;
         end
         ST_SERIAL: begin
            if (serial_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      is_digit = (req_chan.payload.char_code >= CHAR_ZERO)
              && (req_chan.payload.char_code <= CHAR_NINE);
      digit    = is_digit ? 4'(req_chan.payload.char_code - CHAR_ZERO) : 4'd0;

      leap      = (year_ff[1:0] == 2'd0);
      month_ok  = (month_ff != 7'd0) && (month_ff <= MONTH_LAST);
      day_limit = !month_ok ? 5'd0
                : (month_ff == MONTH_FEB) ? (leap ? 5'd29 : 5'd28)
                : MONTH_DAYS[month_ff[3:0]];
      stamp_ok  = !bad_ff && (position_ff == TS_LENGTH) && (year_ff >= EPOCH_YEAR)
               && month_ok && (day_ff != 7'd0) && (day_ff <= {2'd0, day_limit})
               && (hour_ff <= HOUR_MAX) && (minute_ff <= MINUTE_MAX)
               && (second_ff <= MINUTE_MAX);
      days_rest = ADDEND_WIDTH'(14'(year_ff - LEAP_BASE) >> 2)
                + ADDEND_WIDTH'(day_ff) - ADDEND_WIDTH'(1)
                + ADDEND_WIDTH'(CUM_DAYS[month_ff[3:0]])
                + ADDEND_WIDTH'(leap && (month_ff > MONTH_FEB));

      factor  = PASS_FACTOR[pass_ff];
      bit_sum = {1'b0, carry_ff} + (value_ff[0] ? {1'b0, factor} : '0)
              + (FACTOR_WIDTH+1)'(addend_ff[0]);
   end

   always_comb begin
      position_in = position_ff;
      year_in     = year_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      bad_in      = bad_ff;
      value_in    = value_ff;
      addend_in   = addend_ff;
      carry_in    = carry_ff;
      bit_in      = bit_ff;
      pass_in     = pass_ff;
      flag_in     = flag_ff;

      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_ACCUM: begin
            if (accept) begin
               if (!is_digit) begin
                  bad_in = 1'b1;
               end
               priority if (position_ff < POS_MONTH) begin
                  year_in = times_ten_add(year_ff, digit);
               end else if (position_ff < POS_DAY) begin
                  month_in = 7'(times_ten_add({7'd0, month_ff}, digit));
               end else if (position_ff < POS_HOUR) begin
                  day_in = 7'(times_ten_add({7'd0, day_ff}, digit));
               end else if (position_ff < POS_MINUTE) begin
                  hour_in = 7'(times_ten_add({7'd0, hour_ff}, digit));
               end else if (position_ff < POS_SECOND) begin
                  minute_in = 7'(times_ten_add({7'd0, minute_ff}, digit));
               end else if (position_ff < TS_LENGTH) begin
                  second_in = 7'(times_ten_add({7'd0, second_ff}, digit));
               end else begin
               end
               if (position_ff != POS_MAX) begin
                  position_in = position_ff + 5'd1;
               end
               value_in = req_chan.payload.fallback_seconds;
            end
         end
         ST_CHECK: begin
            flag_in  = stamp_ok;
            carry_in = '0;
            bit_in   = '0;
            pass_in  = '0;
            if (stamp_ok) begin
               value_in  = SECONDS_WIDTH'(14'(year_ff - EPOCH_YEAR));
               addend_in = days_rest;
            end
         end
         ST_SERIAL: begin
            value_in  = {bit_sum[0], value_ff[SECONDS_WIDTH-1:1]};
            addend_in = addend_ff >> 1;
            carry_in  = bit_sum[FACTOR_WIDTH:1];
            bit_in    = bit_ff + 6'd1;
            if (bit_end) begin
               carry_in = '0;
               bit_in   = '0;
               pass_in  = pass_ff + 2'd1;
               unique case (pass_ff)
                  2'd0:    addend_in = ADDEND_WIDTH'(hour_ff);
                  2'd1:    addend_in = ADDEND_WIDTH'(minute_ff);
                  default: addend_in = ADDEND_WIDTH'(second_ff);
               endcase
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_payload_in.epoch_seconds = value_ff;
               rsp_payload_in.time_valid    = flag_ff;
               rsp_valid_in = 1'b1;
               position_in  = '0;
               year_in      = '0;
               month_in     = '0;
               day_in       = '0;
               hour_in      = '0;
               minute_in    = '0;
               second_in    = '0;
               bad_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         position_ff  <= '0;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff       <= value_in;
      addend_ff      <= addend_in;
      carry_ff       <= carry_in;
      bit_ff         <= bit_in;
      pass_ff        <= pass_in;
      flag_ff        <= flag_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

[src/ts2e_checker.sv]
`include "timestamp_to_epoch_seconds_assert.svh"

module ts2e_checker
   import ts2e_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            req_last,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   `TS2E_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `TS2E_ASSERT_NEXT(busy_after_last, req_valid && req_ready && req_last, !req_ready)
   `TS2E_ASSERT_IMPLY(rsp_from_busy, $rose(rsp_valid), !$past(req_ready))
   `TS2E_ASSERT_NEXT_ALWAYS(reset_clears_rsp, reset, !rsp_valid)

endmodule

bind timestamp_to_epoch_seconds ts2e_checker u_ts2e_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_last    (req_chan.payload.last_char),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

[test/tb_timestamp_to_epoch_seconds.sv]
module tb_timestamp_to_epoch_seconds;
   import ts2e_pkg::*;

   localparam byte unsigned DIGIT_ZERO   = 8'h30;
   localparam byte unsigned DIGIT_NINE   = 8'h39;
   localparam int unsigned  BASE_YEAR    = 1970;
   localparam int unsigned  LEAP_ORIGIN  = 1969;
   localparam int unsigned  STAMP_LENGTH = 14;
   localparam int unsigned  COUNT_MAX    = 31;
   localparam int unsigned  FEBRUARY     = 2;
   localparam int unsigned  DECEMBER     = 12;
   localparam int unsigned  MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   localparam int CHAR_TARGET    = 1250;
   localparam int HOLD_OFF_LEN   = 600;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {
      STAMP_VALID,
      STAMP_FEB_EDGE,
      STAMP_BAD_FIELD,
      STAMP_EARLY_YEAR,
      STAMP_NON_DIGIT,
      STAMP_WRONG_LENGTH,
      STAMP_NOISE
   } stamp_kind_type;

   class epoch_scoreboard;
      logic [4:0]  char_count;
      logic [13:0] year_acc;
      logic [6:0]  month_acc;
      logic [6:0]  day_acc;
      logic [6:0]  hour_acc;
      logic [6:0]  minute_acc;
      logic [6:0]  second_acc;
      logic        non_digit;
      rsp_payload_type pending_times [$];
      int errors;
      int checked;
      int converted;
      int fallbacks;

      function new();
         clear_fields();
         errors = 0;
         checked = 0;
         converted = 0;
         fallbacks = 0;
      endfunction

      function void clear_fields();
         char_count = '0;
         year_acc   = '0;
         month_acc  = '0;
         day_acc    = '0;
         hour_acc   = '0;
         minute_acc = '0;
         second_acc = '0;
         non_digit  = 1'b0;
      endfunction

      function int pending();
         return pending_times.size();
      endfunction

      // Accumulates one character and, on the last one, predicts the converted time.
      function void note_input(req_payload_type p);
         int unsigned digit, y, mo, dy, hh, mi, ss, feb, lim, pos;
         bit ok;
         longint unsigned days, secs;
         rsp_payload_type r;
         pos = char_count;
         digit = 0;
         if (p.char_code >= DIGIT_ZERO && p.char_code <= DIGIT_NINE) begin
            digit = p.char_code - DIGIT_ZERO;
         end else begin
            non_digit = 1'b1;
         end
         if (pos < 4) begin
            year_acc = 14'(int'(year_acc) * 10 + digit);
         end else if (pos < 6) begin
            month_acc = 7'(int'(month_acc) * 10 + digit);
         end else if (pos < 8) begin
            day_acc = 7'(int'(day_acc) * 10 + digit);
         end else if (pos < 10) begin
            hour_acc = 7'(int'(hour_acc) * 10 + digit);
         end else if (pos < 12) begin
            minute_acc = 7'(int'(minute_acc) * 10 + digit);
         end else if (pos < STAMP_LENGTH) begin
            second_acc = 7'(int'(second_acc) * 10 + digit);
         end
         if (pos < COUNT_MAX) char_count = 5'(pos + 1);
         if (!p.last_char) return;

         y  = year_acc;
         mo = month_acc;
         dy = day_acc;
         hh = hour_acc;
         mi = minute_acc;
         ss = second_acc;
         ok = !non_digit && (pos + 1 == STAMP_LENGTH) && (y >= BASE_YEAR);
         feb = (y % 4 != 0) ? 28 : 29;
         if (mo < 1 || mo > DECEMBER) begin
            ok = 1'b0;
            lim = 0;
         end else begin
            lim = (mo == FEBRUARY) ? feb : MONTH_LEN[mo];
         end
         if (dy < 1 || dy > lim || hh > 23 || mi > 59 || ss > 59) ok = 1'b0;

         if (ok) begin
            days = longint'(y - BASE_YEAR) * 365 + longint'((y - LEAP_ORIGIN) / 4)
                 + longint'(dy) - 1;
            for (int m = 1; m < mo; m++) begin
               days += (m == FEBRUARY) ? feb : MONTH_LEN[m];
            end
            secs = ((days * 24 + hh) * 60 + mi) * 60 + ss;
            r.epoch_seconds = secs[SECONDS_WIDTH-1:0];
            r.time_valid = 1'b1;
         end else begin
            r.epoch_seconds = p.fallback_seconds;
            r.time_valid = 1'b0;
         end
         pending_times.push_back(r);
         clear_fields();
      endfunction

      function void check_result(rsp_payload_type r);
         rsp_payload_type want;
         if (pending_times.size() == 0) begin
            $display("%0t: unexpected result: epoch_seconds %0d time_valid %0b",
                     $time, r.epoch_seconds, r.time_valid);
            errors++;
            return;
         end
         want = pending_times.pop_front();
         checked++;
         if (want.time_valid) converted++;
         else fallbacks++;
         if (r.epoch_seconds !== want.epoch_seconds) begin
            $display("%0t: epoch_seconds mismatch: expected %0d actual %0d",
                     $time, want.epoch_seconds, r.epoch_seconds);
            errors++;
         end
         if (r.time_valid !== want.time_valid) begin
            $display("%0t: time_valid mismatch: expected %0b actual %0b",
                     $time, want.time_valid, r.time_valid);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ts2e_stream_if #(.payload_type(req_payload_type)) req_if ();
   ts2e_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   timestamp_to_epoch_seconds dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   epoch_scoreboard sb;
   int  chars_sent = 0;
   int  stamps_sent = 0;
   int  idle_cycles = 0;
   bit  steady_sender = 1'b0;
   bit  hold_off_done = 1'b0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) sb.note_input(req_if.payload);
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [SECONDS_WIDTH-1:0] random_seconds();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return SECONDS_WIDTH'({$urandom(), $urandom()});
      endcase
   endfunction

   function automatic int unsigned pick_field(int unsigned lo, int unsigned hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   function automatic int unsigned month_days(int unsigned y, int unsigned mo);
      if (mo == FEBRUARY && y % 4 == 0) return 29;
      return MONTH_LEN[mo];
   endfunction

   function automatic void push_digits(ref byte unsigned q[$], input int unsigned value,
                                       input int count);
      int unsigned scale;
      scale = 1;
      for (int i = 1; i < count; i++) scale *= 10;
      for (int i = 0; i < count; i++) begin
         q.push_back(8'(DIGIT_ZERO + (value / scale) % 10));
         scale /= 10;
      end
   endfunction

   task automatic send_char(input byte unsigned c, input bit last);
      int gap;
      req_payload_type p;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      p.char_code = c;
      p.last_char = last;
      p.fallback_seconds = random_seconds();
      req_if.payload <= p;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      chars_sent++;
   endtask

   task automatic send_sequence(input byte unsigned q[$]);
      steady_sender = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < q.size(); i++) begin
         send_char(q[i], i == q.size() - 1);
      end
      stamps_sent++;
   endtask

   task automatic send_random_stamp();
      byte unsigned q[$];
      stamp_kind_type kind;
      int unsigned y, mo, dy, hh, mi, ss, lim, n;
      byte unsigned c;
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) kind = STAMP_VALID;
      else if (r < 68) kind = STAMP_FEB_EDGE;
      else if (r < 76) kind = STAMP_BAD_FIELD;
      else if (r < 82) kind = STAMP_EARLY_YEAR;
      else if (r < 88) kind = STAMP_NON_DIGIT;
      else if (r < 94) kind = STAMP_WRONG_LENGTH;
      else kind = STAMP_NOISE;

      case ($urandom_range(0, 9))
         0: y = BASE_YEAR;
         1: y = 2099;
         2: y = 2100;
         3: y = 9999;
         4, 5: y = $urandom_range(9999, BASE_YEAR);
         default: y = $urandom_range(2099, BASE_YEAR);
      endcase
      mo = pick_field(1, DECEMBER);
      lim = month_days(y, mo);
      dy = pick_field(1, lim);
      hh = pick_field(0, 23);
      mi = pick_field(0, 59);
      ss = pick_field(0, 59);

      case (kind)
         STAMP_FEB_EDGE: begin
            y = $urandom_range(2099, BASE_YEAR);
            mo = FEBRUARY;
            dy = $urandom_range(30, 28);
         end
         STAMP_BAD_FIELD: begin
            case ($urandom_range(0, 4))
               0: mo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(99, DECEMBER + 1);
               1: dy = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(99, lim + 1);
               2: hh = $urandom_range(99, 24);
               3: mi = $urandom_range(99, 60);
               default: ss = $urandom_range(99, 60);
            endcase
         end
         STAMP_EARLY_YEAR: y = pick_field(0, BASE_YEAR - 1);
         default: ;
      endcase

      push_digits(q, y, 4);
      push_digits(q, mo, 2);
      push_digits(q, dy, 2);
      push_digits(q, hh, 2);
      push_digits(q, mi, 2);
      push_digits(q, ss, 2);

      case (kind)
         STAMP_NON_DIGIT: begin
            do c = 8'($urandom_range(0, 255)); while (c >= DIGIT_ZERO && c <= DIGIT_NINE);
            q[$urandom_range(STAMP_LENGTH - 1, 0)] = c;
         end
         STAMP_WRONG_LENGTH: begin
            if ($urandom_range(0, 1) == 0) begin
               n = $urandom_range(STAMP_LENGTH - 1, 1);
               while (q.size() > n) void'(q.pop_back());
            end else begin
               n = $urandom_range(40, STAMP_LENGTH + 1);
               while (q.size() < n) q.push_back(8'(DIGIT_ZERO + $urandom_range(9, 0)));
            end
         end
         STAMP_NOISE: begin
            q.delete();
            n = $urandom_range(20, 1);
            repeat (n) q.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      send_sequence(q);
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_off_done && sb.checked >= 5) begin
            // Hold the result side off while characters keep coming, so the
            // output register fills and the input stalls.
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            int gap;
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      byte unsigned q[$];
      sb = new();
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The epoch itself, a short timestamp full of non-digits, and a lone last character.
      push_digits(q, 1970, 4);
      push_digits(q, 101, 4);
      push_digits(q, 0, 6);
      send_sequence(q);
      q = '{8'h00, 8'hFF, 8'h32, 8'h2F, 8'h3A, 8'h7F, 8'h80, 8'h39, 8'h30, 8'h31};
      send_sequence(q);
      q = '{DIGIT_NINE};
      send_sequence(q);

      while (chars_sent < CHAR_TARGET) send_random_stamp();
      req_if.valid <= 1'b0;
      @(posedge clock);

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters in %0d timestamps; %0d results checked.",
               chars_sent, stamps_sent, sb.checked);
      $display("%0d timestamps converted, %0d fell back to the supplied time.",
               sb.converted, sb.fallbacks);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/ts2e_pkg.sv
src/ts2e_stream_if.sv
src/timestamp_to_epoch_seconds.sv
src/ts2e_checker.sv
test/tb_timestamp_to_epoch_seconds.sv
